// File: rtl/core/dfsv_pkg.sv
// ----------------------------------------------------------------------------
// dfsv_pkg
// Shared types, constants and the byte-wide CRC-32 step for the file
// stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dfsv_pkg;

    localparam int SUFFIX_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]  GZ_MAGIC0 = 8'h1f;
    localparam logic [7:0]  GZ_MAGIC1 = 8'h8b;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC  = 2'd2;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_GZIP  = 2'd2;

    typedef enum logic [2:0] {
        R_OK      = 3'd0,
        R_SIZE    = 3'd1,
        R_EMPTY   = 3'd2,
        R_CRC     = 3'd3,
        R_FRAMING = 3'd4,
        R_MAGIC   = 3'd5
    } t_reason;

    // one byte as classified by the front end
    typedef struct packed {
        logic       first;
        logic       second;
        logic       zero;
        logic       last;
        logic [7:0] data;
    } t_item;

    // verdict, packed so that file_ok lands in the lowest bit
    typedef struct packed {
        logic [31:0] crc_value;
        logic [31:0] entry_count;
        t_reason     fail_reason;
        logic        file_ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dfsv_front.sv
// ----------------------------------------------------------------------------
// dfsv_front
// Accepts file bytes, tags zero bytes and the first two bytes of each file,
// and pushes the tagged transaction into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsv_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [7:0]     i_s_tdata,   // [7:0] data_byte
    input  wire logic           i_s_tlast,   // is_last
    input  wire logic           i_q_full,
    output logic                o_push,
    output dfsv_pkg::t_item     o_push_item
);
    import dfsv_pkg::*;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic       accept;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_push_item.first  = (r_pos == POS_FIRST);
        o_push_item.second = (r_pos == POS_SECOND);
        o_push_item.zero   = (i_s_tdata == 8'd0);
        o_push_item.last   = i_s_tlast;
        o_push_item.data   = i_s_tdata;
    end

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_s_tlast) begin
                n_pos = POS_FIRST;
            end else if (r_pos != POS_LATER) begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dfsv_queue.sv
// ----------------------------------------------------------------------------
// dfsv_queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsv_queue #(
    parameter int DEPTH = dfsv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dfsv_pkg::t_item i_push_item,
    output logic                o_full,
    output logic                o_valid,
    output dfsv_pkg::t_item     o_item,
    input  wire logic           i_pop
);
    import dfsv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dfsv_back.sv
// ----------------------------------------------------------------------------
// dfsv_back
// Runs the CRC-32, byte counter, head capture and index-record framer on
// queued bytes and registers the verdict on the last byte of each file.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsv_back #(
    parameter int SUFFIX_BYTES = dfsv_pkg::SUFFIX_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_file_kind,
    input  wire logic [31:0]    i_expected_size,
    input  wire logic [31:0]    i_expected_crc,
    input  wire logic           i_q_valid,
    input  wire dfsv_pkg::t_item i_q_item,
    output logic                o_pop,
    output logic                o_res_valid,
    output dfsv_pkg::t_result   o_res,
    input  wire logic           i_res_ready
);
    import dfsv_pkg::*;

    localparam int SUF_W = $clog2(SUFFIX_BYTES + 1);

    logic [31:0]        r_crc;
    logic [31:0]        r_count;
    logic               r_nonempty;
    logic [SUF_W-1:0]   r_suffix;
    logic [31:0]        r_entries;
    logic [15:0]        r_head;
    logic               r_empty_seen;
    logic               r_out_valid;
    t_result            r_out;

    logic [31:0]        n_crc;
    logic [31:0]        n_count;
    logic               n_nonempty;
    logic [SUF_W-1:0]   n_suffix;
    logic [31:0]        n_entries;
    logic [15:0]        n_head;
    logic               n_empty_seen;
    logic               n_out_valid;

    logic               is_index;
    logic               is_gz;
    logic               pop;
    logic [31:0]        crc_final;
    t_reason            reason;
    t_result            result;

    assign is_index    = (i_file_kind == KIND_INDEX);
    assign is_gz       = (i_file_kind == KIND_GZIP);
    assign pop         = i_q_valid && (!i_q_item.last || !r_out_valid || i_res_ready);
    assign o_pop       = pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_crc        = crc32_byte(r_crc, i_q_item.data);
        n_head       = r_head;
        n_suffix     = r_suffix;
        n_entries    = r_entries;
        n_nonempty   = r_nonempty;
        n_empty_seen = r_empty_seen;
        if (i_q_item.first) begin
            n_head[15:8] = i_q_item.data;
        end
        if (i_q_item.second) begin
            n_head[7:0] = i_q_item.data;
        end
        if (is_index) begin
            if (r_suffix != '0) begin
                n_suffix = r_suffix - 1'b1;
                if (r_suffix == SUF_W'(1) && r_entries != '1) begin
                    n_entries = r_entries + 32'd1;
                end
            end else if (i_q_item.zero) begin
                if (!r_nonempty) begin
                    n_empty_seen = 1'b1;
                end
                n_nonempty = 1'b0;
                n_suffix   = SUF_W'(SUFFIX_BYTES);
            end else begin
                n_nonempty = 1'b1;
            end
        end
        n_count   = (r_count != '1) ? r_count + 32'd1 : r_count;
        crc_final = ~n_crc;

        priority if (n_count != i_expected_size) begin
            reason = R_SIZE;
        end else if (is_index && n_empty_seen) begin
            reason = R_EMPTY;
        end else if (crc_final != i_expected_crc) begin
            reason = R_CRC;
        end else if (is_index && (n_entries == '0 || n_suffix != '0 || n_nonempty)) begin
            reason = R_FRAMING;
        end else if (is_gz && n_head != {GZ_MAGIC0, GZ_MAGIC1}) begin
            reason = R_MAGIC;
        end else begin
            reason = R_OK;
        end

        result.file_ok     = (reason == R_OK);
        result.fail_reason = reason;
        result.entry_count = is_index ? n_entries : 32'd0;
        result.crc_value   = crc_final;

        n_out_valid = r_out_valid && !i_res_ready;
        if (pop && i_q_item.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (pop && i_q_item.last)) begin
            r_crc        <= CRC_INIT;
            r_count      <= '0;
            r_nonempty   <= 1'b0;
            r_suffix     <= '0;
            r_entries    <= '0;
            r_head       <= '0;
            r_empty_seen <= 1'b0;
        end else if (pop) begin
            r_crc        <= n_crc;
            r_count      <= n_count;
            r_nonempty   <= n_nonempty;
            r_suffix     <= n_suffix;
            r_entries    <= n_entries;
            r_head       <= n_head;
            r_empty_seen <= n_empty_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            r_out <= result;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_q_item.last |=> r_count == '0 && r_crc == CRC_INIT && r_suffix == '0)
        else $error("stream state not cleared after last byte");

    a_ok_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.file_ok == (r_out.fail_reason == R_OK))
        else $error("file_ok disagrees with fail_reason");

    a_suffix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_suffix <= SUF_W'(SUFFIX_BYTES))
        else $error("suffix counter out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |-> !(pop && i_q_item.last))
        else $error("pending verdict overwritten");

endmodule

`default_nettype wire

// File: rtl/core/dict_file_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// dict_file_stream_validator_unit
// File stream validator: CRC-32, size, gzip magic and index-record framing
// checks with one verdict per file.
// ----------------------------------------------------------------------------
// Bytes of a file enter on the slave stream, one per transaction, tlast on
// the final byte; one verdict transaction leaves on the master stream per
// file. The unit takes one byte per cycle while the queue is not full: the
// front end tags each byte and writes it into a QUEUE_DEPTH-entry queue, the
// back end updates the CRC-32, counters and framer from the queue head, and
// the verdict waits in an output register. The queue fills only while a
// verdict is held by the sink and the next file's last byte reaches the back
// end. The last byte is written to a queue entry; its verdict is then registered.
// Configuration writes (file kind, expected size, expected CRC) are always
// accepted and must be made between files.
// ----------------------------------------------------------------------------
`default_nettype none

module dict_file_stream_validator_unit #(
    parameter int SUFFIX_BYTES = dfsv_pkg::SUFFIX_BYTES_DEF,
    parameter int QUEUE_DEPTH  = dfsv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [7:0]                         i_s_tdata,   // [7:0] data_byte
    input  wire logic                               i_s_tlast,   // is_last
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [0] file_ok, [3:1] fail_reason, [35:4] entry_count, [67:36] crc_value
    output logic [dfsv_pkg::M_DATA_W-1:0]           o_m_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dfsv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);
    import dfsv_pkg::*;

    logic [1:0]     r_file_kind;
    logic [31:0]    r_expected_size;
    logic [31:0]    r_expected_crc;

    logic           q_full;
    logic           push;
    t_item          push_item;
    logic           q_valid;
    t_item          q_item;
    logic           pop;
    logic           res_valid;
    t_result        res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_kind     <= KIND_PLAIN;
            r_expected_size <= '0;
            r_expected_crc  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILE_KIND:     r_file_kind     <= i_cfg_data[1:0];
                CFG_EXPECTED_SIZE: r_expected_size <= i_cfg_data;
                CFG_EXPECTED_CRC:  r_expected_crc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dfsv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    dfsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (pop)
    );

    dfsv_back #(
        .SUFFIX_BYTES (SUFFIX_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_file_kind     (r_file_kind),
        .i_expected_size (r_expected_size),
        .i_expected_crc  (r_expected_crc),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (pop),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_ready     (i_m_tready)
    );

    assign o_m_tvalid = res_valid;
    assign o_m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, res};

endmodule

`default_nettype wire
